[rtl/sha_pkg.sv]
// SHA-256 byte hasher package: operation codes, state encoding, round constants
// and the round/schedule helper functions. Used by all rtl modules.
package sha_pkg;

  typedef enum logic [1:0] {
    OP_ABSORB  = 2'd0,
    OP_DIGEST  = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  localparam int BlockBytes = 64;
  localparam int LenOffset  = 56;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  function automatic word_t init_word(input logic [2:0] idx);
    word_t v;
    v = 32'h0;
    case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(input word_t v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

[rtl/sha_block_ram.sv]
// Message block store: 16 x 32-bit words, byte writes, one registered read.
// Depends on sha_pkg.
module sha_block_ram
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       wr_en,
  input  logic [5:0] wr_addr,
  input  logic [7:0] wr_data,
  input  logic [3:0] rd_addr,
  output word_t      rd_data
);

  word_t mem [BlockBytes / 4];
  word_t rd_r;

  // write one byte into its lane, read one big-endian word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][31 - 8*wr_addr[1:0] -: 8] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  assign rd_data = rd_r;

endmodule

[rtl/sha_round.sv]
// One SHA-256 compression round with a 16-word rolling message schedule.
// Depends on sha_pkg.
module sha_round
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       init,
  input  logic       step,
  input  logic [5:0] rnd,
  input  word_t      w_in,
  input  word_t      hv_in [8],
  output word_t      wv_out [8]
);

  word_t v_r [8];
  word_t sch_r [16];
  word_t w_cur, s0, s1, t1, t2, e, a;

  always_comb begin
    s0 = ror(sch_r[1], 7) ^ ror(sch_r[1], 18) ^ (sch_r[1] >> 3);
    s1 = ror(sch_r[14], 17) ^ ror(sch_r[14], 19) ^ (sch_r[14] >> 10);
    w_cur = (rnd < 6'd16) ? w_in : (s1 + sch_r[9] + s0 + sch_r[0]);
    e = v_r[4];
    a = v_r[0];
    t1 = v_r[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
       + ((e & v_r[5]) ^ (~e & v_r[6])) + RoundK[rnd] + w_cur;
    t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // load working vars or advance one round
  always_ff @(posedge clk) begin
    if (init) begin
      for (int i = 0; i < 8; i++) v_r[i] <= hv_in[i];
    end else if (step) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) sch_r[i] <= sch_r[i + 1];
      sch_r[15] <= w_cur;
    end
  end

  assign wv_out = v_r;

endmodule

[rtl/sha256_byte_hasher.sv]
// SHA-256 byte hasher top level: control sequencer, chaining state, output
// register. Depends on sha_pkg, sha_block_ram and sha_round.
//
// Usage: input beats carry one operation each (absorb byte, digest, restart).
// Absorb writes the byte into the block memory; the 64th byte of a block
// starts a compression of load, 64 rounds and fold, during which in_tready
// is low. A digest pads a copy of the block and runs one compression (fill
// below 56) or two, then emits eight output beats, word 0 first, with tlast
// on word 7; the live state is unchanged. No byte is taken while the single
// shared round unit compresses a block.
// The rounds read message words from the block memory one per cycle; padding
// bytes are substituted on that read path, so the memory is never altered.
// Reset (rst_n low, synchronous) reloads the initial hash values and clears
// counts; block memory contents are not cleared. When the receiver stalls the
// current output beat holds and the next operation waits.
module sha256_byte_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        out_tlast   // last_word
);

  state_t      state_r, state_nxt;
  word_t       hv_r [8];
  word_t       tmp_r [8];
  logic [63:0] bits_r;
  logic [5:0]  fill_r;
  logic [6:0]  rnd_r;
  logic        dig_r;
  logic        second_r;
  logic        two_r;
  logic [2:0]  oidx_r;
  logic        in_fire;
  logic        ram_we;
  logic [3:0]  ram_ra;
  word_t       ram_rd;
  word_t       w_mux;
  word_t       wv [8];
  word_t       base [8];
  logic [5:0]  wrnd_r;
  logic [5:0]  bidx0, bidx;
  logic [7:0]  byt [4];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign ram_we    = in_fire && (op_t'(in_tuser) == OP_ABSORB);
  assign ram_ra    = rnd_r[3:0];

  sha_block_ram u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(fill_r), .wr_data(in_tdata),
    .rd_addr(ram_ra), .rd_data(ram_rd)
  );

  // substitute padding on the memory read path
  always_comb begin
    bidx0 = {wrnd_r[3:0], 2'd0};
    for (int j = 0; j < 4; j++) begin
      bidx = bidx0 + 6'(j);
      byt[j] = ram_rd[31 - 8*j -: 8];
      if (dig_r) begin
        if (second_r) byt[j] = 8'h0;
        else if (bidx == fill_r) byt[j] = PadByte;
        else if (bidx > fill_r) byt[j] = 8'h0;
        if ((second_r || !two_r) && bidx >= 6'(LenOffset))
          byt[j] = bits_r[63 - 8*(32'(bidx) - LenOffset) -: 8];
      end
    end
    w_mux = {byt[0], byt[1], byt[2], byt[3]};
    for (int i = 0; i < 8; i++) base[i] = dig_r ? tmp_r[i] : hv_r[i];
  end

  sha_round u_round (
    .clk(clk), .init(state_r == ST_LOAD), .step(state_r == ST_ROUND),
    .rnd(wrnd_r), .w_in(w_mux), .hv_in(base), .wv_out(wv)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (op_t'(in_tuser) == OP_DIGEST) state_nxt = ST_LOAD;
          else if (op_t'(in_tuser) == OP_ABSORB && fill_r == 6'd63) state_nxt = ST_LOAD;
        end
      end
      ST_LOAD:  state_nxt = ST_ROUND;
      ST_ROUND: if (wrnd_r == 6'd63) state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (!dig_r) state_nxt = ST_IDLE;
        else if (two_r && !second_r) state_nxt = ST_LOAD;
        else state_nxt = ST_EMIT;
      end
      ST_EMIT:  if (out_tready && oidx_r == 3'd7) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // control and chaining state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) hv_r[i] <= init_word(3'(i));
      bits_r <= '0;
      fill_r <= '0;
      rnd_r <= '0;
      wrnd_r <= '0;
      dig_r <= 1'b0;
      second_r <= 1'b0;
      two_r <= 1'b0;
      oidx_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          rnd_r <= '0;
          wrnd_r <= '0;
          second_r <= 1'b0;
          oidx_r <= '0;
          if (in_fire) begin
            case (op_t'(in_tuser))
              OP_ABSORB: begin
                fill_r <= fill_r + 6'd1;
                bits_r <= bits_r + 64'd8;
                dig_r <= 1'b0;
              end
              OP_RESTART: begin
                for (int i = 0; i < 8; i++) hv_r[i] <= init_word(3'(i));
                bits_r <= '0;
                fill_r <= '0;
              end
              OP_DIGEST: begin
                dig_r <= 1'b1;
                two_r <= (fill_r >= 6'(LenOffset));
                for (int i = 0; i < 8; i++) tmp_r[i] <= hv_r[i];
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          rnd_r <= 7'd1;
          wrnd_r <= '0;
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 7'd1;
          wrnd_r <= wrnd_r + 6'd1;
        end
        ST_FOLD: begin
          rnd_r <= '0;
          wrnd_r <= '0;
          if (dig_r) begin
            for (int i = 0; i < 8; i++) tmp_r[i] <= tmp_r[i] + wv[i];
            second_r <= 1'b1;
          end else begin
            for (int i = 0; i < 8; i++) hv_r[i] <= hv_r[i] + wv[i];
          end
        end
        ST_EMIT: if (out_tready) oidx_r <= oidx_r + 3'd1;
        default: ;
      endcase
    end
  end

  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = {5'd0, oidx_r, tmp_r[oidx_r]};
  assign out_tlast  = (oidx_r == 3'd7);

`ifndef NO_ASSERTIONS
  a_no_in_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken during emit");
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(oidx_r)) else $error("index moved on stall");
  a_fill_zero_after_block: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == ST_FOLD && !dig_r) |-> fill_r == 6'd0)
    else $error("block fold with fill not zero");
`endif

endmodule

[test/testbench.sv]
// Testbench for sha256_byte_hasher: byte-serial SHA-256 with digest and restart.
// Depends on sha_pkg and the rtl; predicts digests with its own SHA-256 code.
`timescale 1ns / 1ps

module testbench;
  import sha_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;

  sha256_byte_hasher i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // Predictor state
  logic [31:0]  chain_h [8];
  logic [63:0]  bit_count;
  logic [7:0]   msg_block [64];
  int unsigned  fill;
  digest_beat_t digest_queue [$];

  int errors = 0;
  int beats_checked = 0;
  int digests_sent = 0;
  bit hold_off = 0;
  bit stall_enable = 1;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // One 64-round compression of blk into hv
  task automatic sha_compress(inout logic [31:0] hv [8], input logic [7:0] blk [64]);
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    r = hv;
    for (int i = 0; i < 64; i++) begin
      t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + KTAB[i] + w[i];
      t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] += r[i];
  endtask

  // Advance the predicted state for one accepted beat
  task automatic predict_hash(op_t op, logic [7:0] data);
    logic [31:0] hv [8];
    logic [7:0]  blk [64];
    int n;
    case (op)
      OP_ABSORB: begin
        msg_block[fill] = data;
        bit_count += 64'd8;
        fill = (fill + 1) % BlockBytes;
        if (fill == 0) sha_compress(chain_h, msg_block);
      end
      OP_RESTART: begin
        chain_h = IV;
        bit_count = '0;
        fill = 0;
      end
      OP_DIGEST: begin
        hv = chain_h;
        blk = msg_block;
        n = fill;
        blk[n] = PadByte;
        n++;
        for (int i = n; i < BlockBytes; i++) blk[i] = 8'h00;
        if (n > LenOffset) begin
          sha_compress(hv, blk);
          for (int i = 0; i < BlockBytes; i++) blk[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) blk[LenOffset + i] = bit_count[63 - 8*i -: 8];
        sha_compress(hv, blk);
        for (int i = 0; i < 8; i++)
          digest_queue.push_back('{hv[i], 3'(i), (i == 7)});
        digests_sent++;
      end
      default: ;
    endcase
  endtask

  // Clock and reset
  initial clk = 0;
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    rst_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Send one beat, then leave valid low unless the next send follows directly
  task automatic send_op(op_t op, logic [7:0] data);
    in_tvalid = 1;
    in_tuser  = op;
    in_tdata  = data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_hash(op, data);
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic random_gap();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic drain_results();
    while (digest_queue.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // Receiver: stall pattern, or long hold-off when requested
  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 0;
      else if (stall_enable) out_tready <= ($urandom_range(0, 3) != 0);
      else out_tready <= 1;
    end
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[31:0], 32'h0);
      end else begin
        exp_beat = digest_queue.pop_front();
        if (out_tdata[31:0] !== exp_beat.word)
          report_mismatch("digest word", out_tdata[31:0], exp_beat.word);
        if (out_tdata[34:32] !== exp_beat.idx)
          report_mismatch("word index", 32'(out_tdata[34:32]), 32'(exp_beat.idx));
        if (out_tdata[39:35] !== 5'd0)
          report_mismatch("fill bits", 32'(out_tdata[39:35]), 32'h0);
        if (out_tlast !== exp_beat.last)
          report_mismatch("last flag", 32'(out_tlast), 32'(exp_beat.last));
        beats_checked++;
      end
    end
  end

  // Directed: empty message, "abc", op 3, restart
  task automatic test_directed();
    send_op(OP_DIGEST, 8'h00);
    send_op(OP_ABSORB, 8'h61);
    send_op(OP_ABSORB, 8'h62);
    send_op(OP_ABSORB, 8'h63);
    send_op(OP_DIGEST, 8'hff);
    send_op(OP_NONE, 8'h5a);
    send_op(OP_DIGEST, 8'h00);
    send_op(OP_RESTART, 8'hff);
    send_op(OP_ABSORB, 8'hff);
    send_op(OP_ABSORB, 8'h00);
    send_op(OP_DIGEST, 8'h00);
    drain_results();
  endtask

  // Fill levels on both sides of the length field and block boundary
  task automatic test_fill_levels();
    int levels [5] = '{55, 56, 63, 64, 0};
    foreach (levels[k]) begin
      send_op(OP_RESTART, 8'h00);
      for (int i = 0; i < levels[k]; i++) send_op(OP_ABSORB, 8'($urandom));
      send_op(OP_DIGEST, 8'h00);
    end
    drain_results();
  endtask

  // Random messages with gaps, digests mid-stream, a little noise
  task automatic test_random();
    int r;
    for (int n = 0; n < 60; n++) begin
      r = $urandom_range(0, 99);
      if (r < 85) send_op(OP_ABSORB, 8'($urandom));
      else if (r < 95) send_op(OP_DIGEST, 8'($urandom));
      else if (r < 98) send_op(OP_RESTART, 8'($urandom));
      else send_op(OP_NONE, 8'($urandom));
      if ($urandom_range(0, 9) < 7) random_gap();
    end
    drain_results();
  endtask

  // Hold the receiver off while several digests are offered
  task automatic test_backpressure();
    hold_off = 1;
    fork
      begin
        for (int i = 0; i < 3; i++) begin
          send_op(OP_ABSORB, 8'($urandom));
          send_op(OP_DIGEST, 8'h00);
        end
      end
      begin
        repeat (600) @(negedge clk);
        hold_off = 0;
      end
    join
    drain_results();
    // Receiver always ready, no sender gaps
    stall_enable = 0;
    for (int i = 0; i < 70; i++) send_op(OP_ABSORB, 8'($urandom));
    send_op(OP_DIGEST, 8'h00);
    drain_results();
    stall_enable = 1;
  endtask

  initial begin
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = OP_NONE;
    chain_h = IV;
    bit_count = '0;
    fill = 0;
    foreach (msg_block[i]) msg_block[i] = 8'h00;
    @(posedge rst_n);
    @(negedge clk);
    test_directed();
    test_fill_levels();
    test_random();
    test_backpressure();
    $display("Covered %0d digests and %0d digest beats over empty, boundary and random messages,",
             digests_sent, beats_checked);
    $display("with sender gaps, receiver stalls and a long receiver hold-off.");
    if (errors == 0 && digest_queue.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Run limit
  initial begin
    #20ms;
    $display("Timeout after %0t", $realtime);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
